/* rtl/rgbhsl_pkg.sv */
// Shared constants and types for the RGB to HSL converter.
`default_nettype none
package rgbhsl_pkg;
	localparam int CH_W    = 8;
	localparam int SUM_W   = 9;
	localparam int NUM_W   = 12;
	localparam int MAG_W   = 11;
	localparam int DIV_N_W = 24;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam int Q_W     = 16;
	localparam int REM_W   = CH_W + 1;
	localparam int HUE_W   = 16;
	localparam int TAB_N   = 1 << CH_W;

	localparam logic [CH_W-1:0]  CH_MAX      = 8'd255;
	localparam logic [SUM_W-1:0] SUM_MID     = 9'd255;
	localparam logic [SUM_W-1:0] SUM_TOP     = 9'd510;
	localparam logic [MAG_W+1:0] HUE_SECTOR  = 13'd3840;
	localparam logic [CH_W-1:0]  FLOOR_RESET = 8'd1;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} rgbhsl_en_t;
endpackage
`default_nettype wire

/* rtl/rgb_to_hsl_converter.sv */
// Top level of the RGB to HSL converter: pipeline control, divider pair and output stage.
// An accepted request passes through stages s1 to s5; s5 is the output register stage.
// Throughput: one pixel per cycle unless out_stall; a stage moves when empty or the next moves.
// A stalled output holds its result while empty stages upstream still fill.
// Reset clears all stage valid bits and sets chroma_floor to 1.
`default_nettype none
module rgb_to_hsl_converter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]          cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]          red_in,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]          green_in,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]          blue_in,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [rgbhsl_pkg::HUE_W-1:0]       hue,
	output logic [rgbhsl_pkg::Q_W-1:0]                saturation,
	output logic [rgbhsl_pkg::SUM_W-1:0]              lightness_x2,
	output logic [rgbhsl_pkg::CH_W-1:0]               chroma
);
	import rgbhsl_pkg::*;

	logic [CH_W-1:0] chroma_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_floor_q <= FLOOR_RESET;
		end else if (cfg_we) begin
			chroma_floor_q <= cfg_wdata;
		end
	end

	logic       v_s1, v_s2, v_s3, v_s4, v_s5;
	rgbhsl_en_t en;

	always_comb begin
		en.s5 = !v_s5 || !out_stall;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	logic [DIV_N_W-1:0] hue_n_s2, sat_n_s2;
	logic [RECIP_W-1:0] hue_r_s2, sat_r_s2;
	logic [CH_W-1:0]    hue_d_s2, sat_d_s2;
	logic               neg_s2, hue_en_s2, sat_en_s2;
	logic [CH_W-1:0]    chroma_s2;
	logic [SUM_W-1:0]   sum_s2;

	rgbhsl_front u_front (
		.clk          (clk),
		.en           (en),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.chroma_floor (chroma_floor_q),
		.hue_n_s2     (hue_n_s2),
		.hue_r_s2     (hue_r_s2),
		.hue_d_s2     (hue_d_s2),
		.sat_n_s2     (sat_n_s2),
		.sat_r_s2     (sat_r_s2),
		.sat_d_s2     (sat_d_s2),
		.neg_s2       (neg_s2),
		.hue_en_s2    (hue_en_s2),
		.sat_en_s2    (sat_en_s2),
		.chroma_s2    (chroma_s2),
		.sum_s2       (sum_s2)
	);

	logic [Q_W-1:0] hue_q, sat_q;

	rgbhsl_div u_hue_div (
		.clk  (clk),
		.en   (en),
		.n_s2 (hue_n_s2),
		.r_s2 (hue_r_s2),
		.d_s2 (hue_d_s2),
		.quot (hue_q)
	);

	rgbhsl_div u_sat_div (
		.clk  (clk),
		.en   (en),
		.n_s2 (sat_n_s2),
		.r_s2 (sat_r_s2),
		.d_s2 (sat_d_s2),
		.quot (sat_q)
	);

	logic               neg_s3, hue_en_s3, sat_en_s3;
	logic [CH_W-1:0]    chroma_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic               neg_s4, hue_en_s4, sat_en_s4;
	logic [CH_W-1:0]    chroma_s4;
	logic [SUM_W-1:0]   sum_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			neg_s3    <= neg_s2;
			hue_en_s3 <= hue_en_s2;
			sat_en_s3 <= sat_en_s2;
			chroma_s3 <= chroma_s2;
			sum_s3    <= sum_s2;
		end
		if (en.s4) begin
			neg_s4    <= neg_s3;
			hue_en_s4 <= hue_en_s3;
			sat_en_s4 <= sat_en_s3;
			chroma_s4 <= chroma_s3;
			sum_s4    <= sum_s3;
		end
	end

	logic [HUE_W-1:0] hue_mag, hue_val;

	always_comb begin
		hue_mag = HUE_W'(hue_q);
		if (!hue_en_s4) begin
			hue_val = '0;
		end else if (neg_s4) begin
			hue_val = -hue_mag;
		end else begin
			hue_val = hue_mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			hue          <= signed'(hue_val);
			saturation   <= sat_en_s4 ? sat_q : '0;
			lightness_x2 <= sum_s4;
			chroma       <= chroma_s4;
		end
	end
endmodule
`default_nettype wire

/* rtl/rgbhsl_front.sv */
// Front end: max/min, chroma, lightness, hue numerator and divider operand setup.
`default_nettype none
module rgbhsl_front (
	input  wire logic                           clk,
	input  wire rgbhsl_pkg::rgbhsl_en_t         en,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]    red_in,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]    green_in,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]    blue_in,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]    chroma_floor,
	output logic [rgbhsl_pkg::DIV_N_W-1:0]      hue_n_s2,
	output logic [rgbhsl_pkg::RECIP_W-1:0]      hue_r_s2,
	output logic [rgbhsl_pkg::CH_W-1:0]         hue_d_s2,
	output logic [rgbhsl_pkg::DIV_N_W-1:0]      sat_n_s2,
	output logic [rgbhsl_pkg::RECIP_W-1:0]      sat_r_s2,
	output logic [rgbhsl_pkg::CH_W-1:0]         sat_d_s2,
	output logic                                neg_s2,
	output logic                                hue_en_s2,
	output logic                                sat_en_s2,
	output logic [rgbhsl_pkg::CH_W-1:0]         chroma_s2,
	output logic [rgbhsl_pkg::SUM_W-1:0]        sum_s2
);
	import rgbhsl_pkg::*;

	logic [RECIP_W-1:0] recip_tab [TAB_N];

	for (genvar i = 0; i < TAB_N; i++) begin : g_recip
		localparam logic [RECIP_W-1:0] RV = (i == 0) ? '0 :
			RECIP_W'((64'd1 << RECIP_SHIFT) / ((i == 0) ? 1 : i));
		assign recip_tab[i] = RV;
	end

	logic [CH_W-1:0]         mx, mn, c;
	logic [SUM_W-1:0]        sum;
	logic [CH_W-1:0]         den;
	logic signed [NUM_W-1:0] num;
	logic signed [NUM_W-1:0] r_e, g_e, b_e, c_e;

	always_comb begin
		r_e = NUM_W'(signed'({1'b0, red_in}));
		g_e = NUM_W'(signed'({1'b0, green_in}));
		b_e = NUM_W'(signed'({1'b0, blue_in}));
		mx  = (red_in > green_in) ? red_in : green_in;
		mx  = (mx > blue_in) ? mx : blue_in;
		mn  = (red_in < green_in) ? red_in : green_in;
		mn  = (mn < blue_in) ? mn : blue_in;
		c   = mx - mn;
		c_e = NUM_W'(signed'({1'b0, c}));
		sum = SUM_W'(mx) + SUM_W'(mn);
		den = (sum >= SUM_MID) ? CH_W'(SUM_TOP - sum) : CH_W'(sum);
		if (mx == red_in) begin
			num = g_e - b_e;
		end else if (mx == green_in) begin
			num = b_e - r_e + (c_e <<< 1);
		end else begin
			num = r_e - g_e + (c_e <<< 2);
		end
	end

	logic [CH_W-1:0]         c_s1, den_s1;
	logic [SUM_W-1:0]        sum_s1;
	logic signed [NUM_W-1:0] num_s1;
	logic                    hue_en_s1, sat_en_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			c_s1      <= c;
			den_s1    <= den;
			sum_s1    <= sum;
			num_s1    <= num;
			hue_en_s1 <= (c >= chroma_floor) && (c != '0);
			sat_en_s1 <= (c != '0) && (sum != SUM_TOP);
		end
	end

	logic [MAG_W-1:0]   mag;
	logic [DIV_N_W-1:0] hn, sn;

	always_comb begin
		mag = num_s1[NUM_W-1] ? MAG_W'(-num_s1) : MAG_W'(num_s1);
		hn  = DIV_N_W'(mag) * DIV_N_W'(HUE_SECTOR);
		sn  = (DIV_N_W'(c_s1) << Q_W) - DIV_N_W'(c_s1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hue_n_s2  <= hn;
			hue_r_s2  <= recip_tab[c_s1];
			hue_d_s2  <= c_s1;
			sat_n_s2  <= sn;
			sat_r_s2  <= recip_tab[den_s1];
			sat_d_s2  <= den_s1;
			neg_s2    <= num_s1[NUM_W-1];
			hue_en_s2 <= hue_en_s1;
			sat_en_s2 <= sat_en_s1;
			chroma_s2 <= c_s1;
			sum_s2    <= sum_s1;
		end
	end
endmodule
`default_nettype wire

/* rtl/rgbhsl_div.sv */
// Pipelined reciprocal divider: estimate by multiply, then one remainder correction.
`default_nettype none
module rgbhsl_div (
	input  wire logic                              clk,
	input  wire rgbhsl_pkg::rgbhsl_en_t            en,
	input  wire logic [rgbhsl_pkg::DIV_N_W-1:0]    n_s2,
	input  wire logic [rgbhsl_pkg::RECIP_W-1:0]    r_s2,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]       d_s2,
	output logic [rgbhsl_pkg::Q_W-1:0]             quot
);
	import rgbhsl_pkg::*;

	logic [DIV_N_W+RECIP_W-1:0] prod;
	logic [Q_W-1:0]             q0_s3, q0_s4;
	logic [DIV_N_W-1:0]         n_s3;
	logic [CH_W-1:0]            d_s3, d_s4;
	logic [DIV_N_W-1:0]         back;
	logic [DIV_N_W-1:0]         diff;
	logic [REM_W-1:0]           rem_s4;
	logic [Q_W:0]               q_inc;

	assign prod = (DIV_N_W+RECIP_W)'(n_s2) * (DIV_N_W+RECIP_W)'(r_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q0_s3 <= prod[RECIP_SHIFT +: Q_W];
			n_s3  <= n_s2;
			d_s3  <= d_s2;
		end
	end

	assign back = DIV_N_W'(q0_s3) * DIV_N_W'(d_s3);
	assign diff = n_s3 - back;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q0_s4  <= q0_s3;
			d_s4   <= d_s3;
			rem_s4 <= diff[REM_W-1:0];
		end
	end

	assign q_inc = {1'b0, q0_s4} + (Q_W+1)'(rem_s4 >= REM_W'(d_s4));
	assign quot  = q_inc[Q_W] ? '1 : q_inc[Q_W-1:0];
endmodule
`default_nettype wire
